// ===== sv/ftn_pkg.sv =====
// ----------------------------------------------------------------------------
// ftn_pkg
// Shared constants, types and helper functions for the note quantizer.
// ----------------------------------------------------------------------------
package ftn_pkg;

    localparam int FREQ_W         = 20;
    localparam int EXP_W          = 5;
    localparam int MANT_W         = 32;
    localparam int FRAC_W         = 20;
    localparam int NOTE_W         = 6;
    localparam int NAME_W         = 4;
    localparam int CENT_W         = 18;
    localparam int CFG_IDX_W      = 2;
    localparam int NOTE_COUNT_DEF = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd2;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [FREQ_W-1:0] REF_RST   = 20'd112640;
    localparam logic [FREQ_W-1:0] LOWER_RST = 20'd2560;
    localparam logic [FREQ_W-1:0] UPPER_RST = 20'd120320;

    localparam int SEMI_STEP  = 1600;
    localparam int CENT_SCALE = 19200;
    localparam int GRID_BASE  = 76800;

    typedef struct packed {
        logic              fzero;
        logic              in_rng;
        logic [EXP_W-1:0]  ef;
        logic [EXP_W-1:0]  er;
        logic [MANT_W-1:0] mf;
        logic [MANT_W-1:0] mr;
        logic [FRAC_W-1:0] ff;
        logic [FRAC_W-1:0] fr;
    } t_log_lane;

    function automatic logic [EXP_W-1:0] msb_pos(input logic [FREQ_W-1:0] v);
        logic [EXP_W-1:0] p;
        p = '0;
        for (int i = 0; i < FREQ_W; i++) begin
            if (v[i]) begin
                p = EXP_W'(i);
            end
        end
        return p;
    endfunction

    // one squaring step: {result bit, new mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        p = m * m;
        if (p[2*MANT_W-1]) begin
            return {1'b1, p[2*MANT_W-1:MANT_W]};
        end else begin
            return {1'b0, p[2*MANT_W-2:MANT_W-1]};
        end
    endfunction

endpackage

// ===== sv/ftn_log_norm.sv =====
// ----------------------------------------------------------------------------
// ftn_log_norm
// Input stage: leading-one detect and mantissa normalize for both lanes,
// range flag against the limits.
// ----------------------------------------------------------------------------
module ftn_log_norm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    output logic                      o_rdy,
    input  logic [ftn_pkg::FREQ_W-1:0] i_freq,
    input  logic [ftn_pkg::FREQ_W-1:0] i_ref,
    input  logic [ftn_pkg::FREQ_W-1:0] i_lower,
    input  logic [ftn_pkg::FREQ_W-1:0] i_upper,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output ftn_pkg::t_log_lane        o_lane
);
    import ftn_pkg::*;

    logic             r_vld;
    t_log_lane        r_lane;
    t_log_lane        n_lane;
    logic [FREQ_W-1:0] ref_eff;

    assign o_rdy = !r_vld || i_rdy;
    assign ref_eff = (i_ref == '0) ? FREQ_W'(1) : i_ref;

    always_comb begin
        n_lane        = '0;
        n_lane.fzero  = (i_freq == '0);
        n_lane.in_rng = (i_freq > i_lower) && (i_freq < i_upper);
        n_lane.ef     = msb_pos(i_freq);
        n_lane.er     = msb_pos(ref_eff);
        n_lane.mf     = MANT_W'({{(MANT_W-FREQ_W){1'b0}}, i_freq} << (EXP_W'(MANT_W-1) - n_lane.ef));
        n_lane.mr     = MANT_W'({{(MANT_W-FREQ_W){1'b0}}, ref_eff} << (EXP_W'(MANT_W-1) - n_lane.er));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

// ===== sv/ftn_sq_stage.sv =====
// ----------------------------------------------------------------------------
// ftn_sq_stage
// One log2 fraction bit per lane by squaring the normalized mantissa.
// ----------------------------------------------------------------------------
module ftn_sq_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  ftn_pkg::t_log_lane i_lane,
    output logic               o_vld,
    input  logic               i_rdy,
    output ftn_pkg::t_log_lane o_lane
);
    import ftn_pkg::*;

    logic            r_vld;
    t_log_lane       r_lane;
    t_log_lane       n_lane;
    logic [MANT_W:0] sf;
    logic [MANT_W:0] sr;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        sf        = sq_step(i_lane.mf);
        sr        = sq_step(i_lane.mr);
        n_lane    = i_lane;
        n_lane.mf = sf[MANT_W-1:0];
        n_lane.mr = sr[MANT_W-1:0];
        n_lane.ff = {i_lane.ff[FRAC_W-2:0], sf[MANT_W]};
        n_lane.fr = {i_lane.fr[FRAC_W-2:0], sr[MANT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

// ===== sv/ftn_note_calc.sv =====
// ----------------------------------------------------------------------------
// ftn_note_calc
// Log difference to 1/16 cent position, note bin, name and offset, in four
// register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module ftn_note_calc #(
    parameter int NOTE_COUNT = ftn_pkg::NOTE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  ftn_pkg::t_log_lane          i_lane,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [$clog2(NOTE_COUNT)-1:0] o_note,
    output logic [ftn_pkg::NAME_W-1:0]  o_name,
    output logic signed [ftn_pkg::CENT_W-1:0] o_cent,
    output logic                        o_in_rng
);
    import ftn_pkg::*;

    localparam int NW    = $clog2(NOTE_COUNT);
    localparam int D_W   = EXP_W + FRAC_W + 1;
    localparam int P_W   = D_W + 16;
    localparam int X_W   = 23;
    localparam int Y_W   = X_W + 1;
    localparam int Y_MAX = SEMI_STEP * (NOTE_COUNT - 1);
    localparam int T_W   = $clog2(Y_MAX / 64 + 1);
    localparam int RECIP = 2622;
    localparam int C_W   = Y_W + 1;

    logic [3:0] r_vld;
    logic [3:0] stg_rdy;

    assign stg_rdy[3] = !r_vld[3] || i_rdy;
    assign stg_rdy[2] = !r_vld[2] || stg_rdy[3];
    assign stg_rdy[1] = !r_vld[1] || stg_rdy[2];
    assign stg_rdy[0] = !r_vld[0] || stg_rdy[1];
    assign o_rdy      = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_vld;
            if (stg_rdy[1]) r_vld[1] <= r_vld[0];
            if (stg_rdy[2]) r_vld[2] <= r_vld[1];
            if (stg_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage a: scaled log difference
    logic signed [D_W-1:0] d;
    logic signed [P_W-1:0] n_prod, r_prod;
    logic [1:0]            r_fl_a;

    always_comb begin
        d      = signed'({1'b0, i_lane.ef, i_lane.ff}) - signed'({1'b0, i_lane.er, i_lane.fr});
        n_prod = d * signed'(16'(CENT_SCALE));
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0] && i_vld) begin
            r_prod <= n_prod;
            r_fl_a <= {i_lane.fzero, i_lane.in_rng};
        end
    end

    // stage b: round to grid position, clamp checks
    logic signed [X_W-1:0] n_x, r_x_b;
    logic signed [Y_W-1:0] y;
    logic                  n_lo, n_hi, r_lo, r_hi;
    logic [T_W-1:0]        n_t, r_t;
    logic [1:0]            r_fl_b;

    always_comb begin
        n_x  = X_W'((r_prod + P_W'(signed'(1 << (FRAC_W - 1)))) >>> FRAC_W)
               + X_W'(signed'(GRID_BASE));
        y    = Y_W'(n_x) + Y_W'(signed'(SEMI_STEP / 2));
        n_lo = y < 0;
        n_hi = y >= Y_W'(signed'(Y_MAX));
        n_t  = y[T_W+5:6];
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1] && r_vld[0]) begin
            r_x_b  <= n_x;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_t    <= n_t;
            r_fl_b <= r_fl_a;
        end
    end

    // stage c: note bin by reciprocal multiply (divide by 25 after the shift)
    logic [T_W+11:0]       qp;
    logic [NW-1:0]         n_note, r_note_c;
    logic signed [X_W-1:0] r_x_c;
    logic [1:0]            r_fl_c;

    always_comb begin
        qp = (T_W+12)'(r_t) * (T_W+12)'(RECIP);
        if (r_lo) begin
            n_note = '0;
        end else if (r_hi) begin
            n_note = NW'(NOTE_COUNT - 1);
        end else begin
            n_note = NW'(qp >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2] && r_vld[1]) begin
            r_note_c <= n_note;
            r_x_c    <= r_x_b;
            r_fl_c   <= r_fl_b;
        end
    end

    // stage d: offset, saturation, name
    logic [7:0]             n8;
    logic [15:0]            q12p;
    logic [7:0]             q12;
    logic [7:0]             nm;
    logic signed [C_W-1:0]  c;
    logic signed [CENT_W-1:0] n_cent, r_cent;
    logic [NW-1:0]          n_note_d, r_note_d;
    logic [NAME_W-1:0]      n_name, r_name;
    logic                   r_inr;

    always_comb begin
        n8   = 8'(r_note_c);
        q12p = 16'(n8) * 16'd171;
        q12  = 8'(q12p >> 11);
        nm   = n8 - 8'(q12 * 8'd12);
        c    = C_W'(r_x_c) - C_W'(signed'({1'b0, 18'(r_note_c) * 18'(SEMI_STEP)}));
        if (c < C_W'(signed'(-(1 << (CENT_W - 1))))) begin
            n_cent = {1'b1, {(CENT_W-1){1'b0}}};
        end else if (c > C_W'(signed'((1 << (CENT_W - 1)) - 1))) begin
            n_cent = {1'b0, {(CENT_W-1){1'b1}}};
        end else begin
            n_cent = CENT_W'(c);
        end
        n_note_d = r_note_c;
        n_name   = NAME_W'(nm);
        if (r_fl_c[1]) begin
            n_cent   = {1'b1, {(CENT_W-1){1'b0}}};
            n_note_d = '0;
            n_name   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3] && r_vld[2]) begin
            r_cent   <= n_cent;
            r_note_d <= n_note_d;
            r_name   <= n_name;
            r_inr    <= r_fl_c[0];
        end
    end

    assign o_vld    = r_vld[3];
    assign o_note   = r_note_d;
    assign o_name   = r_name;
    assign o_cent   = r_cent;
    assign o_in_rng = r_inr;

endmodule

// ===== sv/frequency_to_note_cents.sv =====
// ----------------------------------------------------------------------------
// frequency_to_note_cents
// Quantizes a pitch in 1/256 Hz to the equal-tempered note grid with name,
// cent offset in 1/16 cent and an in-range flag.
//
//   channel  direction  handshake             payload
//   in       request    i_valid / o_ready     i_frequency
//   out      result     o_valid / i_ready     o_note_num o_note_name
//                                             o_cent_offset o_in_range
//   cfg      write      i_cfg_we              i_cfg_idx i_cfg_data
//
// one request per cycle unless the output stalls; pipeline of normalize, 20 squaring stages
// for the two log2 lanes and 4 note stages
// each stage holds its own valid bit and stalls only when full and blocked
// synchronous active-low reset clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module frequency_to_note_cents #(
    parameter int NOTE_COUNT = ftn_pkg::NOTE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ftn_pkg::FREQ_W-1:0]     i_frequency,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ftn_pkg::NOTE_W-1:0]     o_note_num,
    output logic [ftn_pkg::NAME_W-1:0]     o_note_name,
    output logic signed [ftn_pkg::CENT_W-1:0] o_cent_offset,
    output logic                           o_in_range,
    input  logic                           i_cfg_we,
    input  logic [ftn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ftn_pkg::FREQ_W-1:0]     i_cfg_data
);
    import ftn_pkg::*;

    localparam int NW = $clog2(NOTE_COUNT);

    logic [FREQ_W-1:0] r_ref, r_lower, r_upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= REF_RST;
            r_lower <= LOWER_RST;
            r_upper <= UPPER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REF:   r_ref   <= i_cfg_data;
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic      vld [0:FRAC_W];
    logic      rdy [0:FRAC_W];
    t_log_lane lane[0:FRAC_W];
    logic [NW-1:0] note;

    ftn_log_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid),
        .o_rdy   (o_ready),
        .i_freq  (i_frequency),
        .i_ref   (r_ref),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .o_vld   (vld[0]),
        .i_rdy   (rdy[0]),
        .o_lane  (lane[0])
    );

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_sq
        ftn_sq_stage u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[k-1]),
            .o_rdy   (rdy[k-1]),
            .i_lane  (lane[k-1]),
            .o_vld   (vld[k]),
            .i_rdy   (rdy[k]),
            .o_lane  (lane[k])
        );
    end

    ftn_note_calc #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (vld[FRAC_W]),
        .o_rdy    (rdy[FRAC_W]),
        .i_lane   (lane[FRAC_W]),
        .o_vld    (o_valid),
        .i_rdy    (i_ready),
        .o_note   (note),
        .o_name   (o_note_name),
        .o_cent   (o_cent_offset),
        .o_in_rng (o_in_range)
    );

    assign o_note_num = NOTE_W'(note);

    a_name_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_note_name < 4'd12)
        else $error("note name out of range");

    a_name_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && note < NW'(12) |-> o_note_name == NAME_W'(note))
        else $error("note name mismatch");

    a_note_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> note <= NW'(NOTE_COUNT - 1))
        else $error("note index beyond grid");

    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule
